// ===== rtl/bteq_pkg.sv =====
// ----------------------------------------------------------------------------
// bteq_pkg
// Shared types, constants and the coefficient generator for the bass/treble
// shelving equaliser.
// ----------------------------------------------------------------------------
package bteq_pkg;

   localparam int COEF_WIDTH     = 24;
   localparam int COEF_FRAC_BITS = 20;
   localparam int GAIN_LIMIT_DB  = 15;

   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_MAX  = 32767;
   localparam int SAMPLE_MIN  = -32768;
   localparam int GAIN_W      = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = GAIN_W;

   localparam logic [CSR_INDEX_W-1:0] REG_BASS_GAIN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TREBLE_GAIN = 2'd1;

   localparam int NUM_TAPS   = 5;
   localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
   localparam int TAP_CNT_W  = $clog2(NUM_TAPS + 1);

   localparam logic [TAP_IDX_W-1:0] TAP_B0 = 3'd0;
   localparam logic [TAP_IDX_W-1:0] TAP_B1 = 3'd1;
   localparam logic [TAP_IDX_W-1:0] TAP_B2 = 3'd2;
   localparam logic [TAP_IDX_W-1:0] TAP_A1 = 3'd3;
   localparam logic [TAP_IDX_W-1:0] TAP_A2 = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   typedef enum logic {
      SECT_TREBLE,
      SECT_BASS
   } section_type;

   typedef struct packed {
      logic accumulate;
      logic clear;
   } mac_ctrl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } hist_type;

   // Q30 design constants
   localparam logic signed [63:0] Q30_ONE  = 64'sd1073741824;
   localparam logic signed [63:0] COS_LOW  = 64'sd1072555235;
   localparam logic signed [63:0] SIN_LOW  = 64'sd50465557;
   localparam logic signed [63:0] COS_HIGH = 64'sd957231315;
   localparam logic signed [63:0] SIN_HIGH = 64'sd486446003;
   localparam logic signed [63:0] POW_UP   = 64'sd1105095651;
   localparam logic signed [63:0] POW_DOWN = 64'sd1043277569;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // rounded Q30 product
   function automatic logic signed [63:0] mul30(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] part;
      ua   = mag64(a);
      ub   = mag64(b);
      hi   = ub >> 15;
      lo   = ub & 64'h7FFF;
      part = ua * hi + ((ua * lo + 64'h4000) >> 15);
      return with_sign((part + 64'h4000) >> 15, a[63] ^ b[63]);
   endfunction

   // rounded Q30 quotient by shift and subtract; non-positive divisor gives 0
   function automatic logic signed [63:0] div30(input logic signed [63:0] n,
                                                input logic signed [63:0] d);
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] q;
      logic [63:0] r;
      int          i;
      if (d <= 0) begin
         return 64'sd0;
      end
      un = mag64(n);
      ud = 64'(d);
      q  = '0;
      r  = '0;
      for (i = 63; i >= 0; i--) begin
         r = {r[62:0], un[i]};
         if (r >= ud) begin
            r    = r - ud;
            q[i] = 1'b1;
         end
      end
      for (i = 0; i < 30; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= ud) begin
            r    = r - ud;
            q[0] = 1'b1;
         end
      end
      if ((r << 1) >= ud) begin
         q = q + 64'd1;
      end
      return with_sign(q, n[63]);
   endfunction

   function automatic logic signed [63:0] to_coef(input logic signed [63:0] v,
                                                  input int cw, input int fb);
      int                 sh;
      logic [63:0]        m;
      logic signed [63:0] r;
      logic signed [63:0] lim;
      sh  = 30 - fb;
      m   = mag64(v);
      m   = (m + (64'd1 << (sh - 1))) >> sh;
      r   = with_sign(m, v[63]);
      lim = (64'sd1 <<< (cw - 1)) - 64'sd1;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim - 64'sd1) begin
         r = -lim - 64'sd1;
      end
      return r;
   endfunction

   // one cookbook shelf coefficient (b0 b1 b2 a1 a2, a-terms negated)
   function automatic logic signed [63:0] make_coef(input int gain, input logic high,
                                                    input int tap, input int cw,
                                                    input int fb, input int limit);
      int                 g;
      int                 n;
      int                 k;
      logic signed [63:0] s;
      logic signed [63:0] a;
      logic signed [63:0] ap1;
      logic signed [63:0] am1;
      logic signed [63:0] c;
      logic signed [63:0] tsa;
      logic signed [63:0] amc;
      logic signed [63:0] apc;
      logic signed [63:0] a0;
      logic signed [63:0] res;
      g = gain;
      if (g > limit) begin
         g = limit;
      end
      if (g < -limit) begin
         g = -limit;
      end
      n = (g < 0) ? -g : g;
      s = Q30_ONE;
      for (k = 0; k < n; k++) begin
         s = mul30(s, (g < 0) ? POW_DOWN : POW_UP);
      end
      a   = mul30(s, s);
      c   = high ? COS_HIGH : COS_LOW;
      tsa = 64'sd2 * mul30(s, high ? SIN_HIGH : SIN_LOW);
      ap1 = a + Q30_ONE;
      am1 = a - Q30_ONE;
      amc = mul30(am1, c);
      apc = mul30(ap1, c);
      if (high) begin
         a0 = ap1 - amc + tsa;
         case (tap)
            0:       res = mul30(a, div30(ap1 + amc + tsa, a0));
            1:       res = mul30(a, div30(-64'sd2 * (am1 + apc), a0));
            2:       res = mul30(a, div30(ap1 + amc - tsa, a0));
            3:       res = -div30(64'sd2 * (am1 - apc), a0);
            default: res = -div30(ap1 - amc - tsa, a0);
         endcase
      end else begin
         a0 = ap1 + amc + tsa;
         case (tap)
            0:       res = mul30(a, div30(ap1 - amc + tsa, a0));
            1:       res = mul30(a, div30(64'sd2 * (am1 - apc), a0));
            2:       res = mul30(a, div30(ap1 - amc - tsa, a0));
            3:       res = div30(64'sd2 * (am1 + apc), a0);
            default: res = -div30(ap1 + amc - tsa, a0);
         endcase
      end
      return to_coef(res, cw, fb);
   endfunction

endpackage

// ===== rtl/bteq_if.sv =====
// ----------------------------------------------------------------------------
// bteq_if
// Request and response channels of the equaliser (valid/ready).
// ----------------------------------------------------------------------------
interface bteq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bteq_pkg::SAMPLE_W-1:0] sample_in;
   logic                                 block_start;

   modport source (output valid, output sample_in, output block_start, input ready);
   modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

interface bteq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bteq_pkg::SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/bteq_coef_rom.sv =====
// ----------------------------------------------------------------------------
// bteq_coef_rom
// Shelf coefficient tables, one set per gain step, with registered read.
// ----------------------------------------------------------------------------
module bteq_coef_rom #(
   parameter int COEF_WIDTH     = bteq_pkg::COEF_WIDTH,
   parameter int COEF_FRAC_BITS = bteq_pkg::COEF_FRAC_BITS,
   parameter int GAIN_LIMIT_DB  = bteq_pkg::GAIN_LIMIT_DB
) (
   input  logic                                  clock,
   input  logic                                  fetch,
   input  bteq_pkg::section_type                 sect,
   input  logic [bteq_pkg::TAP_IDX_W-1:0]        tap,
   input  logic signed [bteq_pkg::GAIN_W-1:0]    bass_gain,
   input  logic signed [bteq_pkg::GAIN_W-1:0]    treble_gain,
   output logic signed [COEF_WIDTH-1:0]          coef_ff
);

   localparam int NUM_GAINS  = 2 * GAIN_LIMIT_DB + 1;
   localparam int GAIN_IDX_W = $clog2(NUM_GAINS);
   localparam logic signed [GAIN_IDX_W:0] LIM = (GAIN_IDX_W + 1)'(GAIN_LIMIT_DB);

   logic signed [COEF_WIDTH-1:0] treble_tab [NUM_GAINS][bteq_pkg::NUM_TAPS];
   logic signed [COEF_WIDTH-1:0] bass_tab   [NUM_GAINS][bteq_pkg::NUM_TAPS];
   logic [GAIN_IDX_W-1:0]        bass_idx;
   logic [GAIN_IDX_W-1:0]        treble_idx;
   logic signed [COEF_WIDTH-1:0] coef_in;

   for (genvar gi = 0; gi < NUM_GAINS; gi++) begin : g_gain
      for (genvar ti = 0; ti < bteq_pkg::NUM_TAPS; ti++) begin : g_tap
         localparam logic signed [63:0] TREBLE_C = bteq_pkg::make_coef(
            gi - GAIN_LIMIT_DB, 1'b1, ti, COEF_WIDTH, COEF_FRAC_BITS, GAIN_LIMIT_DB);
         localparam logic signed [63:0] BASS_C = bteq_pkg::make_coef(
            gi - GAIN_LIMIT_DB, 1'b0, ti, COEF_WIDTH, COEF_FRAC_BITS, GAIN_LIMIT_DB);
         assign treble_tab[gi][ti] = TREBLE_C[COEF_WIDTH-1:0];
         assign bass_tab[gi][ti]   = BASS_C[COEF_WIDTH-1:0];
      end
   end

   function automatic logic [GAIN_IDX_W-1:0] gain_index(
      input logic signed [bteq_pkg::GAIN_W-1:0] gain);
      logic signed [GAIN_IDX_W:0] g;
      g = (GAIN_IDX_W + 1)'(gain);
      if (g > LIM) begin
         g = LIM;
      end
      if (g < -LIM) begin
         g = -LIM;
      end
      return GAIN_IDX_W'(g + LIM);
   endfunction

   always_comb begin
      bass_idx   = gain_index(bass_gain);
      treble_idx = gain_index(treble_gain);
      if (sect == bteq_pkg::SECT_BASS) begin
         coef_in = bass_tab[bass_idx][tap];
      end else begin
         coef_in = treble_tab[treble_idx][tap];
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== rtl/bteq_mac.sv =====
// ----------------------------------------------------------------------------
// bteq_mac
// Shared multiply-accumulate unit with truncate-toward-zero and saturation.
// ----------------------------------------------------------------------------
module bteq_mac #(
   parameter int COEF_WIDTH     = bteq_pkg::COEF_WIDTH,
   parameter int COEF_FRAC_BITS = bteq_pkg::COEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  bteq_pkg::mac_ctrl_type                ctrl,
   input  logic signed [COEF_WIDTH-1:0]          coef,
   input  logic signed [bteq_pkg::SAMPLE_W-1:0]  operand,
   output logic signed [bteq_pkg::SAMPLE_W-1:0]  result
);

   localparam int ACC_W  = COEF_WIDTH + bteq_pkg::SAMPLE_W + 3;
   localparam int PROD_W = COEF_WIDTH + bteq_pkg::SAMPLE_W;
   localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(bteq_pkg::SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(bteq_pkg::SAMPLE_MIN);

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  trunc;

   always_comb begin
      prod   = PROD_W'(coef) * PROD_W'(operand);
      acc_in = (ctrl.clear ? '0 : acc_ff) + ACC_W'(prod);
      if (acc_ff[ACC_W-1]) begin
         trunc = (acc_ff + RND_NEG) >>> COEF_FRAC_BITS;
      end else begin
         trunc = acc_ff >>> COEF_FRAC_BITS;
      end
      if (trunc > SAT_MAX) begin
         result = bteq_pkg::SAMPLE_W'(SAT_MAX);
      end else if (trunc < SAT_MIN) begin
         result = bteq_pkg::SAMPLE_W'(SAT_MIN);
      end else begin
         result = trunc[bteq_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accumulate) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/bass_treble_shelving_equalizer_unit.sv =====
// ----------------------------------------------------------------------------
// bass_treble_shelving_equalizer_unit
// Treble high shelf (3300 Hz) followed by bass low shelf (330 Hz), Q 0.5.
//
// Use:
//  - req_bus carries one PCM sample per beat; block_start set on a beat
//    clears both sections' histories before that sample is filtered.
//  - rsp_bus returns exactly one equalised sample per request beat, in order.
//  - csr_we/csr_index/csr_wdata set bass gain (index 0) and treble gain
//    (index 1) in dB; write only while no sample is in flight.
//  - Each sample runs ten MACs through one shared multiplier: per section
//    the sequencer fetches coefficients pipelined with the MAC, then a
//    final step rounds, saturates and shifts the history.
//  - Response valid rises on the same edge that ready rises again; a new
//    request is not taken until the previous sample is finished.
//  - A finished sample sits in the response register; the next request is
//    taken and filtered meanwhile, and only its final step waits for the
//    response register to drain.
//  - Reset: gains 0 dB, histories zero, no response pending.
// ----------------------------------------------------------------------------
module bass_treble_shelving_equalizer_unit #(
   parameter int COEF_WIDTH     = bteq_pkg::COEF_WIDTH,
   parameter int COEF_FRAC_BITS = bteq_pkg::COEF_FRAC_BITS,
   parameter int GAIN_LIMIT_DB  = bteq_pkg::GAIN_LIMIT_DB
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bteq_req_if.sink                              req_bus,
   bteq_rsp_if.source                            rsp_bus,
   input  logic                                  csr_we,
   input  logic [bteq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bteq_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam logic [bteq_pkg::TAP_CNT_W-1:0] LAST_STEP = bteq_pkg::TAP_CNT_W'(bteq_pkg::NUM_TAPS);
   localparam logic [bteq_pkg::TAP_CNT_W-1:0] FIRST_ACC = bteq_pkg::TAP_CNT_W'(1);

   bteq_pkg::state_type                  state_ff, state_in;
   bteq_pkg::section_type                sect_ff, sect_in;
   logic [bteq_pkg::TAP_CNT_W-1:0]       step_ff, step_in;
   logic signed [bteq_pkg::GAIN_W-1:0]   bass_gain_ff, bass_gain_in;
   logic signed [bteq_pkg::GAIN_W-1:0]   treble_gain_ff, treble_gain_in;
   bteq_pkg::hist_type                   treble_hist_ff, treble_hist_in;
   bteq_pkg::hist_type                   bass_hist_ff, bass_hist_in;
   logic signed [bteq_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic signed [bteq_pkg::SAMPLE_W-1:0] operand_ff, operand_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [bteq_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   bteq_pkg::hist_type                   cur_hist;
   bteq_pkg::hist_type                   new_hist;
   logic signed [bteq_pkg::SAMPLE_W-1:0] cur_x;
   logic signed [bteq_pkg::SAMPLE_W-1:0] mac_result;
   logic signed [COEF_WIDTH-1:0]         coef;
   logic                                 rom_fetch;
   bteq_pkg::mac_ctrl_type               mac_ctrl;

   bteq_coef_rom #(
      .COEF_WIDTH     (COEF_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .GAIN_LIMIT_DB  (GAIN_LIMIT_DB)
   ) u_rom (
      .clock       (clock),
      .fetch       (rom_fetch),
      .sect        (sect_ff),
      .tap         (step_ff[bteq_pkg::TAP_IDX_W-1:0]),
      .bass_gain   (bass_gain_ff),
      .treble_gain (treble_gain_ff),
      .coef_ff     (coef)
   );

   bteq_mac #(
      .COEF_WIDTH     (COEF_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .coef    (coef),
      .operand (operand_ff),
      .result  (mac_result)
   );

   assign req_bus.ready      = (state_ff == bteq_pkg::ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;

   always_comb begin
      state_in       = state_ff;
      sect_in        = sect_ff;
      step_in        = step_ff;
      bass_gain_in   = bass_gain_ff;
      treble_gain_in = treble_gain_ff;
      treble_hist_in = treble_hist_ff;
      bass_hist_in   = bass_hist_ff;
      x_in           = x_ff;
      operand_in     = operand_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      rsp_sample_in  = rsp_sample_ff;
      rom_fetch      = 1'b0;
      mac_ctrl       = '0;

      if (csr_we) begin
         case (csr_index)
            bteq_pkg::REG_BASS_GAIN:   bass_gain_in   = csr_wdata;
            bteq_pkg::REG_TREBLE_GAIN: treble_gain_in = csr_wdata;
            default: ;
         endcase
      end

      // bass input is the treble output, already in the treble y1 slot
      if (sect_ff == bteq_pkg::SECT_BASS) begin
         cur_hist = bass_hist_ff;
         cur_x    = treble_hist_ff.y1;
      end else begin
         cur_hist = treble_hist_ff;
         cur_x    = x_ff;
      end
      new_hist.x1 = cur_x;
      new_hist.x2 = cur_hist.x1;
      new_hist.y1 = mac_result;
      new_hist.y2 = cur_hist.y1;

      case (step_ff[bteq_pkg::TAP_IDX_W-1:0])
         bteq_pkg::TAP_B0: operand_in = cur_x;
         bteq_pkg::TAP_B1: operand_in = cur_hist.x1;
         bteq_pkg::TAP_B2: operand_in = cur_hist.x2;
         bteq_pkg::TAP_A1: operand_in = cur_hist.y1;
         bteq_pkg::TAP_A2: operand_in = cur_hist.y2;
         default:          operand_in = operand_ff;
      endcase

      case (state_ff)
         bteq_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               x_in    = req_bus.sample_in;
               sect_in = bteq_pkg::SECT_TREBLE;
               step_in = '0;
               if (req_bus.block_start) begin
                  treble_hist_in = '0;
                  bass_hist_in   = '0;
               end
               state_in = bteq_pkg::ST_RUN;
            end
         end
         bteq_pkg::ST_RUN: begin
            rom_fetch           = (step_ff < LAST_STEP);
            mac_ctrl.accumulate = (step_ff != '0);
            mac_ctrl.clear      = (step_ff == FIRST_ACC);
            if (step_ff == LAST_STEP) begin
               state_in = bteq_pkg::ST_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         bteq_pkg::ST_FIN: begin
            if (sect_ff == bteq_pkg::SECT_TREBLE) begin
               treble_hist_in = new_hist;
               sect_in        = bteq_pkg::SECT_BASS;
               step_in        = '0;
               state_in       = bteq_pkg::ST_RUN;
            end else if (!rsp_valid_ff || rsp_bus.ready) begin
               bass_hist_in  = new_hist;
               rsp_sample_in = mac_result;
               rsp_valid_in  = 1'b1;
               state_in      = bteq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bteq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bteq_pkg::ST_IDLE;
         sect_ff        <= bteq_pkg::SECT_TREBLE;
         step_ff        <= '0;
         bass_gain_ff   <= '0;
         treble_gain_ff <= '0;
         treble_hist_ff <= '0;
         bass_hist_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sect_ff        <= sect_in;
         step_ff        <= step_in;
         bass_gain_ff   <= bass_gain_in;
         treble_gain_ff <= treble_gain_in;
         treble_hist_ff <= treble_hist_in;
         bass_hist_ff   <= bass_hist_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      operand_ff    <= operand_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule
